// ===== hdl/ets_pkg.sv =====
// ----------------------------------------------------------------------------
// ets_pkg: shared types and constants of the expression token scanner
// Token kinds, character codes, queue entry layout and default sizes.
// ----------------------------------------------------------------------------
package ets_pkg;

   // Default sizes
   localparam int ETS_POSITION_BITS = 16;
   localparam int ETS_QUEUE_DEPTH   = 4;

   localparam int KIND_BITS  = 4;
   localparam int START_BITS = 16;
   localparam int LEN_BITS   = 16;

   // Token kinds
   localparam logic [KIND_BITS-1:0] KIND_EOF    = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_ERROR  = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_PLUS   = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_MINUS  = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_STAR   = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_SLASH  = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_COMMA  = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_EQUAL  = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_IDENT  = 4'd9;

   // Character codes
   localparam logic [7:0] CHAR_NUL        = 8'h00;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_STAR       = 8'h2A;
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_COMMA      = 8'h2C;
   localparam logic [7:0] CHAR_EQUAL      = 8'h3D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [START_BITS-1:0] start;
      logic [LEN_BITS-1:0]   len;
   } token_type;

   // One queue entry: the tokens caused by one byte
   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [KIND_BITS-1:0] op_kind(input logic [7:0] c);
      logic [KIND_BITS-1:0] k;
      case (c)
         CHAR_PLUS:  k = KIND_PLUS;
         CHAR_MINUS: k = KIND_MINUS;
         CHAR_STAR:  k = KIND_STAR;
         CHAR_SLASH: k = KIND_SLASH;
         CHAR_COMMA: k = KIND_COMMA;
         CHAR_EQUAL: k = KIND_EQUAL;
         default:    k = KIND_ERROR;
      endcase
      return k;
   endfunction

endpackage

// ===== hdl/ets_if.sv =====
// ----------------------------------------------------------------------------
// ets_if: request and response channel interfaces
// Valid/ready channels carrying source bytes and tokens.
// ----------------------------------------------------------------------------
interface ets_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface ets_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_class;
   logic [15:0] token_start;
   logic [15:0] token_len;
   logic        last_of_run;

   modport source (output valid, output token_class, output token_start,
                   output token_len, output last_of_run, input ready);
   modport sink   (input valid, input token_class, input token_start,
                   input token_len, input last_of_run, output ready);
endinterface

// ===== hdl/ets_front.sv =====
// ----------------------------------------------------------------------------
// ets_front: byte classifier and scan state
// Accepts one byte per cycle unless the queue is full, updates the scan mode
// and positions, and pushes the tokens the byte causes as one queue entry.
// ----------------------------------------------------------------------------
module ets_front
   import ets_pkg::*;
#(
   parameter int POSITION_BITS = ETS_POSITION_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [7:0]   req_char_in,
   output logic         req_ready,
   input  q_status_type status,
   output push_type     push
);

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_INT   = 2'd1;
   localparam logic [1:0] MODE_FRAC  = 2'd2;
   localparam logic [1:0] MODE_IDENT = 2'd3;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0]      LEN_MAX = {LEN_BITS{1'b1}};

   logic [1:0]               mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] pstart_ff, pstart_in;
   logic [LEN_BITS-1:0]      plen_ff, plen_in;

   logic                     accept;
   logic                     is_digit, is_letter, is_space, is_word;
   logic                     extend, flush, second;
   logic [POSITION_BITS-1:0] pos_adv;
   token_type                tok_a, tok_b;

   assign req_ready = !status.full;
   assign accept    = req_valid && req_ready;

   // Classify the byte
   assign is_digit  = (req_char_in >= "0") && (req_char_in <= "9");
   assign is_letter = ((req_char_in >= "A") && (req_char_in <= "Z")) ||
                      ((req_char_in >= "a") && (req_char_in <= "z"));
   assign is_space  = (req_char_in == CHAR_SPACE) ||
                      ((req_char_in >= CHAR_TAB) && (req_char_in <= CHAR_CR));
   assign is_word   = is_digit || is_letter || (req_char_in == CHAR_UNDERSCORE);
   assign pos_adv   = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;

   // Decide whether the byte extends the pending token
   always_comb begin
      case (mode_ff)
         MODE_INT:   extend = is_digit || (req_char_in == CHAR_DOT);
         MODE_FRAC:  extend = is_digit;
         MODE_IDENT: extend = is_word;
         default:    extend = 1'b0;
      endcase
   end

   assign flush  = (mode_ff != MODE_IDLE) && !extend;
   assign second = !((mode_ff != MODE_IDLE) && extend) &&
                   ((req_char_in == CHAR_NUL) || (!is_space && !is_word));

   // Build the flushed token and the byte's own token
   always_comb begin
      tok_a.kind  = (mode_ff == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
      tok_a.start = START_BITS'(pstart_ff);
      tok_a.len   = plen_ff;
      tok_b.start = START_BITS'(pos_ff);
      if (req_char_in == CHAR_NUL) begin
         tok_b.kind = KIND_EOF;
         tok_b.len  = '0;
      end else begin
         tok_b.kind = op_kind(req_char_in);
         tok_b.len  = LEN_BITS'(1);
      end
   end

   // Next scan state
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      if ((mode_ff != MODE_IDLE) && extend) begin
         plen_in = (plen_ff == LEN_MAX) ? plen_ff : plen_ff + 1'b1;
         pos_in  = pos_adv;
         if ((mode_ff == MODE_INT) && (req_char_in == CHAR_DOT)) begin
            mode_in = MODE_FRAC;
         end
      end else if (req_char_in == CHAR_NUL) begin
         mode_in = MODE_IDLE;
         pos_in  = '0;
      end else if (is_word) begin
         mode_in   = is_digit ? MODE_INT : MODE_IDENT;
         pstart_in = pos_ff;
         plen_in   = LEN_BITS'(1);
         pos_in    = pos_adv;
      end else begin
         mode_in = MODE_IDLE;
         pos_in  = pos_adv;
      end
   end

   // Pack the entry: pending token first, then the byte's own
   always_comb begin
      push.valid      = accept && (flush || second);
      push.entry.two  = flush && second;
      push.entry.tok0 = flush ? tok_a : tok_b;
      push.entry.tok1 = tok_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
      end
   end

endmodule

// ===== hdl/ets_queue.sv =====
// ----------------------------------------------------------------------------
// ets_queue: entry queue between front and back
// Small register FIFO of per-byte token entries.
// ----------------------------------------------------------------------------
module ets_queue
   import ets_pkg::*;
#(
   parameter int DEPTH = ETS_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  logic         pop,
   output entry_type    head,
   output q_status_type status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   entry_type             entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !status.full;
   assign do_pop  = pop && !status.empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ===== hdl/ets_back.sv =====
// ----------------------------------------------------------------------------
// ets_back: token emitter
// Splits each queue entry into one or two tokens and holds them in an
// output register until the response channel takes them.
// ----------------------------------------------------------------------------
module ets_back
   import ets_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  entry_type    head,
   input  q_status_type status,
   output logic         pop,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output token_type    rsp_token,
   output logic         rsp_last
);

   logic      valid_ff, valid_in;
   logic      sub_ff, sub_in;
   token_type tok_ff, tok_in;
   logic      last_ff, last_in;
   logic      load;

   assign rsp_valid = valid_ff;
   assign rsp_token = tok_ff;
   assign rsp_last  = last_ff;

   // Load the next token when the output register is free or draining
   assign load = (!valid_ff || rsp_ready) && !status.empty;
   assign pop  = load && (sub_ff || !head.two);

   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      tok_in   = tok_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         tok_in   = sub_ff ? head.tok1 : head.tok0;
         last_in  = sub_ff || !head.two;
         sub_in   = !(sub_ff || !head.two);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      last_ff <= last_in;
   end

endmodule

// ===== hdl/expression_token_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// expression_token_scanner_unit: byte-stream expression tokenizer
// Groups source bytes into number, identifier, operator, error and
// end-of-file tokens.
// ----------------------------------------------------------------------------
// A byte that ends a pending token and also forms a token of its own (an
// operator, an error or a zero byte) yields two tokens; each byte's last
// token carries last_of_run. The front end classifies a byte combinationally,
// so request throughput is one byte per clock for as long as the entry queue
// (QUEUE_DEPTH entries) has room; the output register drains one token per
// clock while the response side is ready, so a long run of two-token bytes
// fills the queue and throttles the request side to the token rate. A byte's
// first token passes through its queue entry and then the output register.
// A zero byte resets the position to zero.
// ----------------------------------------------------------------------------
module expression_token_scanner_unit
   import ets_pkg::*;
#(
   parameter int POSITION_BITS = ETS_POSITION_BITS,
   parameter int QUEUE_DEPTH   = ETS_QUEUE_DEPTH
) (
   input  logic   clock,
   input  logic   reset,
   ets_req_if.sink   req_chan,
   ets_rsp_if.source rsp_chan
);

   push_type     push;
   logic         pop;
   entry_type    head;
   q_status_type status;
   token_type    rsp_token;

   ets_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_char_in (req_chan.char_in),
      .req_ready   (req_chan.ready),
      .status      (status),
      .push        (push)
   );

   ets_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (status)
   );

   ets_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_token (rsp_token),
      .rsp_last  (rsp_chan.last_of_run)
   );

   // Drive response payload
   assign rsp_chan.token_class = rsp_token.kind;
   assign rsp_chan.token_start = rsp_token.start;
   assign rsp_chan.token_len   = rsp_token.len;

`ifndef NO_ASSERTIONS
   // Never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !status.full)
      else $error("entry pushed into full queue");

   // Never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("entry popped from empty queue");

   // An accepted zero byte always produces an entry
   a_eof_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.char_in == CHAR_NUL))
      |-> push.valid)
      else $error("zero byte produced no end-of-file entry");

   // A token loaded from an empty queue would be invented
   a_load_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !$past(rsp_chan.valid) && !$past(reset)) |->
      $past(!status.empty))
      else $error("response raised without a queued entry");
`endif

endmodule
